FILE: design/sof_length_xor_fcs_deframer_unit_defines.svh
// assertion macros shared by the deframer modules
`ifndef SOF_LENGTH_XOR_FCS_DEFRAMER_UNIT_DEFINES_SVH
`define SOF_LENGTH_XOR_FCS_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`else

`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

	localparam logic [7:0] START_BYTE    = 8'hFE;
	localparam logic [7:0] MAX_LEN_RESET = 8'd250;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_LEN   = 3'd1,
		PH_CMD0  = 3'd2,
		PH_CMD1  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	localparam logic [1:0] KIND_CMD0   = 2'd0;
	localparam logic [1:0] KIND_CMD1   = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [1:0] status;
		logic       last;
	} result_t;

endpackage

FILE: design/sfd_parser.sv
`timescale 1ns / 1ps
`include "sof_length_xor_fcs_deframer_unit_defines.svh"

module sfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                fire,
	input  logic [7:0]          byte_in,
	output logic                res_valid,
	output sfd_pkg::result_t    res
);

	sfd_pkg::phase_t phase_q, phase_n;
	logic [7:0] rem_q, rem_n, rem_dec;
	logic [7:0] xor_q, xor_n;
	logic [7:0] max_len_q;
	logic       ends_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sfd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// data counter saturates at zero
	assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;

	always_comb begin
		phase_n = phase_q;
		rem_n   = rem_q;
		xor_n   = xor_q;
		case (phase_q)
			sfd_pkg::PH_LEN: begin
				xor_n = byte_in;
				if (byte_in > max_len_q) begin
					phase_n = sfd_pkg::PH_HUNT;
					rem_n   = 8'd0;
				end else begin
					rem_n   = byte_in;
					phase_n = sfd_pkg::PH_CMD0;
				end
			end
			sfd_pkg::PH_CMD0: begin
				xor_n   = xor_q ^ byte_in;
				phase_n = sfd_pkg::PH_CMD1;
			end
			sfd_pkg::PH_CMD1: begin
				xor_n   = xor_q ^ byte_in;
				phase_n = (rem_q == 8'd0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_DATA;
			end
			sfd_pkg::PH_DATA: begin
				xor_n = xor_q ^ byte_in;
				rem_n = rem_dec;
				if (rem_dec == 8'd0) begin
					phase_n = sfd_pkg::PH_CHECK;
				end
			end
			sfd_pkg::PH_CHECK: begin
				phase_n = sfd_pkg::PH_HUNT;
				rem_n   = 8'd0;
			end
			default: begin
				phase_n = sfd_pkg::PH_HUNT;
				if (byte_in == sfd_pkg::START_BYTE) begin
					phase_n = sfd_pkg::PH_LEN;
					xor_n   = 8'd0;
					rem_n   = 8'd0;
				end
			end
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '{data: byte_in, kind: sfd_pkg::KIND_STATUS,
			status: sfd_pkg::ST_OK, last: 1'b0};
		case (phase_q)
			sfd_pkg::PH_LEN: begin
				if (byte_in > max_len_q) begin
					res_valid  = 1'b1;
					res.data   = 8'd0;
					res.status = sfd_pkg::ST_TOO_LONG;
					res.last   = 1'b1;
				end
			end
			sfd_pkg::PH_CMD0: begin
				res_valid = 1'b1;
				res.kind  = sfd_pkg::KIND_CMD0;
			end
			sfd_pkg::PH_CMD1: begin
				res_valid = 1'b1;
				res.kind  = sfd_pkg::KIND_CMD1;
			end
			sfd_pkg::PH_DATA: begin
				res_valid = 1'b1;
				res.kind  = sfd_pkg::KIND_DATA;
			end
			sfd_pkg::PH_CHECK: begin
				res_valid  = 1'b1;
				res.data   = 8'd0;
				res.status = (byte_in == xor_q) ? sfd_pkg::ST_OK : sfd_pkg::ST_MISMATCH;
				res.last   = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT;
			rem_q   <= 8'd0;
			xor_q   <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			xor_q   <= xor_n;
		end
	end

	assign ends_frame = fire && res_valid && res.last;

	`SFD_ASSERT_IMPL(a_check_no_data_left, clk, arst_n, phase_q == sfd_pkg::PH_CHECK, rem_q == 8'd0)
	`SFD_ASSERT_NEXT(a_status_ends_frame, clk, arst_n, ends_frame, phase_q == sfd_pkg::PH_HUNT)

endmodule

FILE: design/sfd_out_stage.sv
`timescale 1ns / 1ps
`include "sof_length_xor_fcs_deframer_unit_defines.svh"

module sfd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  sfd_pkg::result_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_stall,
	output sfd_pkg::result_t out_res
);

	logic             valid_q;
	sfd_pkg::result_t res_q;

	// free slot or the held result leaves in this cycle
	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	`SFD_ASSERT_IMPL(a_last_only_on_status, clk, arst_n, valid_q && res_q.last, res_q.kind == sfd_pkg::KIND_STATUS)

endmodule

FILE: design/sof_length_xor_fcs_deframer_unit.sv
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------------
// input    | in_valid / in_stall        | rx_byte
// output   | out_valid / out_stall      | out_byte, out_kind, frame_status, last_of_frame
// config   | cfg_wr_en                  | cfg_wr_data (max_payload_length)
//
// one byte per cycle sustained while out_stall stays low; a byte passes from its transfer
// through the input register and parse logic into the result register
// arst_n clears the parse state to hunting and the maximum length to 250
// a stalled output holds its result; in_stall rises only while the input register
// is full and the result register cannot move

module sof_length_xor_fcs_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic [1:0] frame_status,
	output logic       last_of_frame,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             fire;
	logic             res_valid;
	sfd_pkg::result_t res;
	sfd_pkg::result_t out_res;

	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	sfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.byte_in     (byte_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	sfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (fire && res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign out_byte      = out_res.data;
	assign out_kind      = out_res.kind;
	assign frame_status  = out_res.status;
	assign last_of_frame = out_res.last;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [1:0] frame_status;
	logic       last_of_frame;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;

	// bytes waiting to be sent and outputs the parser model says must come
	logic [7:0]       rx_backlog[$];
	sfd_pkg::result_t predicted_outputs[$];

	// parser model state
	sfd_pkg::phase_t model_phase = sfd_pkg::PH_HUNT;
	logic [7:0]      model_remaining = 8'h00;
	logic [7:0]      model_xor = 8'h00;
	logic [7:0]      model_max_len = sfd_pkg::MAX_LEN_RESET;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;

	sof_length_xor_fcs_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.out_kind(out_kind),
		.frame_status(frame_status),
		.last_of_frame(last_of_frame),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		error_count++;
		$display("%0t: %s", $time, msg);
	endtask

	function automatic void push_output(input logic [7:0] data, input logic [1:0] kind,
			input logic [1:0] status, input logic last);
		sfd_pkg::result_t r;
		r.data = data;
		r.kind = kind;
		r.status = status;
		r.last = last;
		predicted_outputs.push_back(r);
	endfunction

	// advance the frame parser model by one received byte
	function automatic void parse_rx_byte(input logic [7:0] b);
		case (model_phase)
			sfd_pkg::PH_LEN: begin
				model_xor = b;
				if (b > model_max_len) begin
					model_phase = sfd_pkg::PH_HUNT;
					model_remaining = 8'h00;
					push_output(8'h00, sfd_pkg::KIND_STATUS, sfd_pkg::ST_TOO_LONG, 1'b1);
				end else begin
					model_remaining = b;
					model_phase = sfd_pkg::PH_CMD0;
				end
			end
			sfd_pkg::PH_CMD0: begin
				model_xor ^= b;
				model_phase = sfd_pkg::PH_CMD1;
				push_output(b, sfd_pkg::KIND_CMD0, sfd_pkg::ST_OK, 1'b0);
			end
			sfd_pkg::PH_CMD1: begin
				model_xor ^= b;
				model_phase = (model_remaining == 8'h00) ? sfd_pkg::PH_CHECK
					: sfd_pkg::PH_DATA;
				push_output(b, sfd_pkg::KIND_CMD1, sfd_pkg::ST_OK, 1'b0);
			end
			sfd_pkg::PH_DATA: begin
				model_xor ^= b;
				if (model_remaining != 8'h00)
					model_remaining = model_remaining - 8'h01;
				if (model_remaining == 8'h00)
					model_phase = sfd_pkg::PH_CHECK;
				push_output(b, sfd_pkg::KIND_DATA, sfd_pkg::ST_OK, 1'b0);
			end
			sfd_pkg::PH_CHECK: begin
				model_phase = sfd_pkg::PH_HUNT;
				model_remaining = 8'h00;
				push_output(8'h00, sfd_pkg::KIND_STATUS,
					(b == model_xor) ? sfd_pkg::ST_OK : sfd_pkg::ST_MISMATCH, 1'b1);
			end
			default: begin
				model_phase = sfd_pkg::PH_HUNT;
				if (b == sfd_pkg::START_BYTE) begin
					model_phase = sfd_pkg::PH_LEN;
					model_xor = 8'h00;
					model_remaining = 8'h00;
				end
			end
		endcase
	endfunction

	// queue one frame; cut >= 0 drops everything after that many body bytes
	function automatic int queue_frame(input int len, input bit good_fcs, input int cut);
		logic [7:0] fcs;
		logic [7:0] b;
		fcs = len[7:0];
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(len[7:0]);
		for (int i = 0; i < len + 2; i++) begin
			if (cut >= 0 && i >= cut)
				return i + 2;
			b = 8'($urandom_range(0, 255));
			fcs ^= b;
			rx_backlog.push_back(b);
		end
		rx_backlog.push_back(good_fcs ? fcs : fcs ^ 8'($urandom_range(1, 255)));
		return len + 5;
	endfunction

	// mostly well-formed frames, some noise, truncations and oversize lengths
	function automatic void queue_random_traffic(input int target);
		int sent;
		int r;
		int len;
		int cap;
		int n;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(99);
			cap = (model_max_len > 16) ? 16 : model_max_len;
			if (r < 8) begin
				n = $urandom_range(1, 3);
				repeat (n)
					rx_backlog.push_back(8'($urandom_range(0, 255)));
				sent += n;
			end else if (r < 16 && model_max_len != 8'hFF) begin
				rx_backlog.push_back(sfd_pkg::START_BYTE);
				rx_backlog.push_back(8'($urandom_range(model_max_len + 1, 255)));
				sent += 2;
			end else begin
				len = (r < 18) ? model_max_len : $urandom_range(0, cap);
				sent += queue_frame(len, $urandom_range(3) != 0,
					(r >= 18 && r < 26) ? $urandom_range(0, len + 2) : -1);
			end
		end
	endfunction

	// everything sent and every expected output seen, plus pipeline slack
	task automatic settle_pipeline();
		@(negedge clk);
		while (rx_backlog.size() != 0 || in_valid || predicted_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		model_max_len = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender: one transfer per accepted byte, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall)
				parse_rx_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= rx_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each output transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		sfd_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					flag_mismatch($sformatf("unexpected output byte=%h kind=%0d status=%0d last=%0b",
						out_byte, out_kind, frame_status, last_of_frame));
				end else begin
					want = predicted_outputs.pop_front();
					if (out_byte !== want.data)
						flag_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
					if (out_kind !== want.kind)
						flag_mismatch($sformatf("out_kind %0d, expected %0d", out_kind, want.kind));
					if (frame_status !== want.status)
						flag_mismatch($sformatf("frame_status %0d, expected %0d",
							frame_status, want.status));
					if (last_of_frame !== want.last)
						flag_mismatch($sformatf("last_of_frame %0b, expected %0b",
							last_of_frame, want.last));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting is dropped
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'hFF);
		rx_backlog.push_back(8'h7F);
		// zero length, good check of all ones
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'hFF);
		rx_backlog.push_back(8'hFF);
		// zero length, good check of zero
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'h00);
		// two data bytes, one of them a start byte, bad check
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(8'h02);
		rx_backlog.push_back(8'hFF);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'h55);
		// lengths just above the limit and the largest
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(sfd_pkg::MAX_LEN_RESET + 8'd1);
		rx_backlog.push_back(sfd_pkg::START_BYTE);
		rx_backlog.push_back(8'hFF);
		queue_random_traffic(200);
		settle_pipeline();

		send_idle_pct = 77;
		write_max_length(8'h00);
		queue_random_traffic(225);
		settle_pipeline();

		send_idle_pct = 0;
		recv_stall_pct = 77;
		write_max_length(8'hFF);
		queue_random_traffic(225);
		settle_pipeline();

		send_idle_pct = 34;
		recv_stall_pct = 34;
		write_max_length(8'($urandom_range(3, 40)));
		queue_random_traffic(225);
		settle_pipeline();
		repeat (6) @(posedge clk);

		if (predicted_outputs.size() != 0)
			flag_mismatch($sformatf("%0d expected outputs never arrived", predicted_outputs.size()));
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d outputs outstanding", predicted_outputs.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/sfd_pkg.sv
design/sfd_parser.sv
design/sfd_out_stage.sv
design/sof_length_xor_fcs_deframer_unit.sv
tb/tb_top.sv
